// ===== hdl/tlbpt_pkg.sv =====
// Shared constants, function codes and interface structs for the TLB and
// page table translate block. No dependencies.
package tlbpt_pkg;

  localparam int TLB_ENTRIES = 16;
  localparam int TLB_IDX_W   = $clog2(TLB_ENTRIES);
  localparam int PAGE_BITS   = 8;
  localparam int OFFSET_BITS = 8;
  localparam int DATA_BITS   = 9;
  localparam int FUNC_BITS   = 2;
  localparam int MAP_DEPTH   = 2 ** PAGE_BITS;
  localparam int MEM_ADDR_W  = PAGE_BITS + OFFSET_BITS;
  localparam int MEM_DEPTH   = 2 ** MEM_ADDR_W;

  typedef enum logic [FUNC_BITS-1:0] {
    FUNC_READ  = 2'd0,
    FUNC_MAP   = 2'd1,
    FUNC_STORE = 2'd2
  } func_t;

  typedef struct packed {
    logic                 hit;
    logic [PAGE_BITS-1:0] frame;
  } tlb_lookup_t;

  typedef struct packed {
    logic                 en;
    logic [PAGE_BITS-1:0] tag;
    logic [PAGE_BITS-1:0] frame;
  } tlb_fill_t;

endpackage

// ===== hdl/tlbpt_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module tlbpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/tlbpt_tlb.sv =====
// Fully associative TLB with FIFO replacement; lowest matching entry wins.
// Depends on tlbpt_pkg.
module tlbpt_tlb
  import tlbpt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic [PAGE_BITS-1:0] tag,
  output tlb_lookup_t          lookup,
  input  tlb_fill_t            fill
);

  logic [PAGE_BITS-1:0]   tags   [TLB_ENTRIES];
  logic [PAGE_BITS-1:0]   frames [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] valid;
  logic [TLB_IDX_W-1:0]   ptr;

  always_comb begin
    lookup = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && tags[i] == tag) begin
        lookup.hit   = 1'b1;
        lookup.frame = frames[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      ptr   <= '0;
    end else if (fill.en) begin
      valid[ptr] <= 1'b1;
      ptr        <= (ptr == TLB_IDX_W'(TLB_ENTRIES - 1)) ? '0 : ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (fill.en) begin
      tags[ptr]   <= fill.tag;
      frames[ptr] <= fill.frame;
    end
  end

endmodule

// ===== hdl/tlb_page_table_translate_read_top.sv =====
// Translate-and-read block: TLB lookup, page table walk and physical memory read.
// Depends on tlbpt_pkg, tlbpt_ram and tlbpt_tlb.
//
// Every beat is captured in S_IDLE on acceptance, which also starts the page table read;
// S_LOOK does the TLB compare (and on a miss the TLB refill and the choice of frame
// from the page table data) and, for a read that translates, starts the registered read of
// physical memory, whose data S_MEM loads into the output register; table writes, memory
// writes, no-ops and faults load their result from S_DONE. The block takes one beat at a
// time, and a new beat can be accepted while the previous result still waits in the
// output register. Page table valid bits live in flip-flops cleared by reset, so no
// clearing pass is needed; physical memory is not initialized.
module tlb_page_table_translate_read_top
  import tlbpt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [FUNC_BITS-1:0]   func,
  input  logic [PAGE_BITS-1:0]   page,
  input  logic [OFFSET_BITS-1:0] offset,
  input  logic [PAGE_BITS-1:0]   frame,
  input  logic                   entry_valid,
  input  logic [DATA_BITS-1:0]   wdata,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [DATA_BITS-1:0]   rdata,
  output logic                   fault,
  output logic                   tlb_hit
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_MEM  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [FUNC_BITS-1:0]   func_q;
  logic [PAGE_BITS-1:0]   page_q;
  logic [OFFSET_BITS-1:0] offset_q;
  logic [PAGE_BITS-1:0]   frame_q;
  logic                   ev_q;
  logic [DATA_BITS-1:0]   wdata_q;
  logic                   hit_q;

  logic [MAP_DEPTH-1:0]   map_valid;
  logic                   map_re, map_we;
  logic [PAGE_BITS-1:0]   map_rdata;

  logic                   mem_re, mem_we;
  logic [MEM_ADDR_W-1:0]  mem_raddr;
  logic [DATA_BITS-1:0]   mem_rdata;

  tlb_lookup_t            lookup;
  tlb_fill_t              fill;

  logic                   accept, out_free, out_load;
  logic [DATA_BITS-1:0]   rdata_next;
  logic                   fault_next, tlb_hit_next;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  tlbpt_tlb u_tlb (
    .clk    (clk),
    .rst    (rst),
    .tag    (page_q),
    .lookup (lookup),
    .fill   (fill)
  );

  tlbpt_ram #(.WIDTH(PAGE_BITS), .DEPTH(MAP_DEPTH)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (page_q),
    .wdata (frame_q),
    .re    (map_re),
    .raddr (page),
    .rdata (map_rdata)
  );

  tlbpt_ram #(.WIDTH(DATA_BITS), .DEPTH(MEM_DEPTH)) u_mem_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr ({frame_q, offset_q}),
    .wdata (wdata_q),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_next   = state;
    map_re       = accept;
    map_we       = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = {lookup.frame, offset_q};
    fill         = '0;
    out_load     = 1'b0;
    rdata_next   = '0;
    fault_next   = 1'b0;
    tlb_hit_next = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        state_next = S_DONE;
        unique case (func_q)
          FUNC_READ: begin
            if (lookup.hit) begin
              mem_re     = 1'b1;
              state_next = S_MEM;
            end else if (map_valid[page_q]) begin
              fill.en    = 1'b1;
              fill.tag   = page_q;
              fill.frame = map_rdata;
              mem_raddr  = {map_rdata, offset_q};
              mem_re     = 1'b1;
              state_next = S_MEM;
            end
          end
          FUNC_MAP:   map_we = 1'b1;
          FUNC_STORE: mem_we = 1'b1;
          default: ;
        endcase
      end
      S_MEM: begin
        rdata_next   = mem_rdata;
        tlb_hit_next = hit_q;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DONE: begin
        fault_next = (func_q == FUNC_READ);
        if (out_free) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      map_valid <= '0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (map_we) begin
        map_valid[page_q] <= ev_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q   <= func;
      page_q   <= page;
      offset_q <= offset;
      frame_q  <= frame;
      ev_q     <= entry_valid;
      wdata_q  <= wdata;
    end
    if (state == S_LOOK) begin
      hit_q <= lookup.hit;
    end
    if (out_load) begin
      rdata   <= rdata_next;
      fault   <= fault_next;
      tlb_hit <= tlb_hit_next;
    end
  end

endmodule

// ===== tb/sv/tlb_page_table_translate_read_top_tb.sv =====
// Self-checking testbench for tlb_page_table_translate_read_top: directed and random
// beats, a scoreboard that predicts TLB, page table and memory behavior per beat.
// Depends on tlbpt_pkg and the block's RTL.
module tlb_page_table_translate_read_top_tb;
  import tlbpt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [FUNC_BITS-1:0] FUNC_NOP = 2'd3;
  localparam int RANDOM_BEATS = 1750;
  localparam int QUIET_FROM   = 1550;
  localparam int POOL_SIZE    = 24;

  typedef struct packed {
    logic [DATA_BITS-1:0] rdata;
    logic                 fault;
    logic                 hit;
  } read_result_t;

  class xlate_scoreboard;
    logic [PAGE_BITS-1:0] tlb_tag   [TLB_ENTRIES];
    logic [PAGE_BITS-1:0] tlb_frame [TLB_ENTRIES];
    bit                   tlb_valid [TLB_ENTRIES];
    logic [TLB_IDX_W-1:0] fill_ptr;
    bit                   map_valid [MAP_DEPTH];
    logic [PAGE_BITS-1:0] map_frame [MAP_DEPTH];
    logic [DATA_BITS-1:0] mem_word  [MEM_DEPTH];
    bit                   mem_set   [MEM_DEPTH];
    read_result_t         expected_q [$];
    int                   mismatches;

    function new();
      fill_ptr   = '0;
      mismatches = 0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        tlb_tag[i]   = '0;
        tlb_frame[i] = '0;
        tlb_valid[i] = 1'b0;
      end
      for (int i = 0; i < MAP_DEPTH; i++) begin
        map_valid[i] = 1'b0;
        map_frame[i] = '0;
      end
    endfunction

    // Lowest matching valid TLB entry wins; otherwise fall back to the page table.
    function bit find_frame(input logic [PAGE_BITS-1:0] pg,
                            output logic [PAGE_BITS-1:0] frm, output bit hit);
      hit = 1'b0;
      frm = '0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        if (!hit && tlb_valid[i] && tlb_tag[i] == pg) begin
          hit = 1'b1;
          frm = tlb_frame[i];
        end
      end
      if (hit) return 1'b1;
      if (map_valid[pg]) begin
        frm = map_frame[pg];
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function bit word_written(input logic [PAGE_BITS-1:0] frm,
                              input logic [OFFSET_BITS-1:0] off);
      return mem_set[{frm, off}];
    endfunction

    function void note(input logic [FUNC_BITS-1:0] fn, input logic [PAGE_BITS-1:0] pg,
                       input logic [OFFSET_BITS-1:0] off, input logic [PAGE_BITS-1:0] frm,
                       input logic ev, input logic [DATA_BITS-1:0] wd);
      read_result_t         r;
      logic [PAGE_BITS-1:0] f;
      bit                   hit;
      r = '0;
      case (fn)
        FUNC_READ: begin
          if (!find_frame(pg, f, hit)) begin
            r.fault = 1'b1;
          end else begin
            if (!hit) begin
              tlb_tag[fill_ptr]   = pg;
              tlb_frame[fill_ptr] = f;
              tlb_valid[fill_ptr] = 1'b1;
              fill_ptr            = fill_ptr + 1'b1;
            end
            r.hit   = hit;
            r.rdata = mem_word[{f, off}];
          end
        end
        FUNC_MAP: begin
          map_valid[pg] = ev;
          map_frame[pg] = ev ? frm : '0;
        end
        FUNC_STORE: begin
          mem_word[{frm, off}] = wd;
          mem_set[{frm, off}]  = 1'b1;
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    function void check(input logic [DATA_BITS-1:0] rd, input logic flt, input logic hit);
      read_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing expected: rdata=%0h fault=%0b tlb_hit=%0b",
                   $realtime, rd, flt, hit);
        return;
      end
      want = expected_q.pop_front();
      if (rd !== want.rdata || flt !== want.fault || hit !== want.hit) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: mismatch rdata exp %0h got %0h, fault exp %0b got %0b, %s",
                   $realtime, want.rdata, rd, want.fault, flt,
                   $sformatf("tlb_hit exp %0b got %0b", want.hit, hit));
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [FUNC_BITS-1:0]   func = '0;
  logic [PAGE_BITS-1:0]   page = '0;
  logic [OFFSET_BITS-1:0] offset = '0;
  logic [PAGE_BITS-1:0]   frame = '0;
  logic                   entry_valid = 1'b0;
  logic [DATA_BITS-1:0]   wdata = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [DATA_BITS-1:0]   rdata;
  logic                   fault;
  logic                   tlb_hit;

  xlate_scoreboard sb = new();
  bit              quiet = 1'b0;
  int              stall_left = 0;
  int              made = 0;

  tlb_page_table_translate_read_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .func(func), .page(page), .offset(offset), .frame(frame),
    .entry_valid(entry_valid), .wdata(wdata),
    .out_valid(out_valid), .out_stall(out_stall),
    .rdata(rdata), .fault(fault), .tlb_hit(tlb_hit)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (rst || quiet) begin
      out_stall = 1'b0;
    end else if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  = 1'b1;
      stall_left = $urandom_range(0, 4);
    end else begin
      out_stall = 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check(rdata, fault, tlb_hit);
  end

  task automatic send_beat(input logic [FUNC_BITS-1:0] fn, input logic [PAGE_BITS-1:0] pg,
                           input logic [OFFSET_BITS-1:0] off,
                           input logic [PAGE_BITS-1:0] frm, input logic ev,
                           input logic [DATA_BITS-1:0] wd);
    @(negedge clk);
    in_valid    = 1'b1;
    func        = fn;
    page        = pg;
    offset      = off;
    frame       = frm;
    entry_valid = ev;
    wdata       = wd;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note(fn, pg, off, frm, ev, wd);
    made++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
    end
  endtask

  // Store the target word first when a read would land on unwritten memory.
  task automatic send_translate(input logic [PAGE_BITS-1:0] pg,
                                input logic [OFFSET_BITS-1:0] off);
    logic [PAGE_BITS-1:0] f;
    bit                   hit;
    if (sb.find_frame(pg, f, hit) && !sb.word_written(f, off))
      send_beat(FUNC_STORE, PAGE_BITS'($urandom), off, f, 1'($urandom),
                DATA_BITS'($urandom));
    send_beat(FUNC_READ, pg, off, PAGE_BITS'($urandom), 1'($urandom),
              DATA_BITS'($urandom));
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [PAGE_BITS-1:0] pool [POOL_SIZE];
    logic [PAGE_BITS-1:0] pg;
    int                   pick;
    bit                   drained;
    drained = 1'b0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    send_beat(FUNC_READ, 8'd0, 8'd0, 8'd0, 1'b0, 9'd0);
    send_beat(FUNC_READ, 8'hff, 8'hff, 8'hff, 1'b1, 9'h1ff);
    send_beat(FUNC_NOP, 8'hff, 8'hff, 8'hff, 1'b1, 9'h1ff);
    send_beat(FUNC_NOP, 8'd0, 8'd0, 8'd0, 1'b0, 9'd0);
    send_beat(FUNC_MAP, 8'd0, 8'd0, 8'hff, 1'b1, 9'd0);
    send_beat(FUNC_STORE, 8'd0, 8'd0, 8'hff, 1'b0, 9'h1ff);
    send_beat(FUNC_STORE, 8'hff, 8'hff, 8'hff, 1'b1, 9'h155);
    send_translate(8'd0, 8'd0);
    send_translate(8'd0, 8'hff);
    send_beat(FUNC_MAP, 8'hff, 8'hff, 8'd0, 1'b1, 9'h1ff);
    send_beat(FUNC_STORE, 8'h55, 8'hff, 8'd0, 1'b0, 9'd0);
    send_beat(FUNC_STORE, 8'haa, 8'd0, 8'd0, 1'b1, 9'h0aa);
    send_translate(8'hff, 8'hff);
    send_translate(8'hff, 8'd0);
    // remap and unmap behind a live TLB entry: stale entry keeps serving
    send_beat(FUNC_MAP, 8'd0, 8'd0, 8'haa, 1'b0, 9'd0);
    send_translate(8'd0, 8'hff);
    send_beat(FUNC_MAP, 8'hff, 8'd0, 8'h55, 1'b1, 9'd0);
    send_translate(8'hff, 8'h80);
    send_beat(FUNC_MAP, 8'h07, 8'd0, 8'h12, 1'b0, 9'd0);
    send_translate(8'h07, 8'h01);
    send_beat(FUNC_MAP, 8'h07, 8'h00, 8'h12, 1'b1, 9'd0);
    send_translate(8'h07, 8'h7f);
    send_translate(8'h07, 8'h7f);
    drain();

    for (int i = 0; i < POOL_SIZE; i++) begin
      pool[i] = PAGE_BITS'($urandom);
      send_beat(FUNC_MAP, pool[i], OFFSET_BITS'($urandom), PAGE_BITS'($urandom), 1'b1,
                DATA_BITS'($urandom));
    end
    made = 0;
    while (made < RANDOM_BEATS) begin
      quiet = (made >= QUIET_FROM);
      if (!drained && made >= RANDOM_BEATS / 2) begin
        drained = 1'b1;
        drain();
      end
      pg = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, POOL_SIZE - 1)]
                                        : PAGE_BITS'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_beat(FUNC_MAP, pg, OFFSET_BITS'($urandom), PAGE_BITS'($urandom),
                  $urandom_range(0, 6) != 0, DATA_BITS'($urandom));
      end else if (pick < 20) begin
        send_beat(FUNC_STORE, PAGE_BITS'($urandom), OFFSET_BITS'($urandom),
                  PAGE_BITS'($urandom), 1'($urandom), DATA_BITS'($urandom));
      end else if (pick < 24) begin
        send_beat(FUNC_NOP, PAGE_BITS'($urandom), OFFSET_BITS'($urandom),
                  PAGE_BITS'($urandom), 1'($urandom), DATA_BITS'($urandom));
      end else begin
        send_translate(pg, OFFSET_BITS'($urandom));
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
